[rtl/dssa_pkg.sv]
// ----------------------------------------------------------------------------
// dssa_pkg
// Shared types and constants for the dual stack shared array block.
// ----------------------------------------------------------------------------
package dssa_pkg;

	localparam int unsigned DEPTH_DEF = 16;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned STATUS_W  = 2;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam logic SEL_LOWER = 1'b0;
	localparam logic SEL_UPPER = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

	typedef struct packed {
		logic                     opcode;
		logic                     stack_select;
		logic signed [WORD_W-1:0] push_value;
	} dssa_cmd_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] pop_value;
		logic [STATUS_W-1:0]      status;
	} dssa_res_t;

	typedef struct packed {
		logic latch;
		logic exec;
	} dssa_ctl_t;

endpackage

[rtl/dual_stack_shared_array.sv]
// ----------------------------------------------------------------------------
// dual_stack_shared_array
// Two LIFO stacks in one store: lower grows up from 0, upper down from top.
// ----------------------------------------------------------------------------
// channel   ports                 handshake
// command   cmd                   start & !busy
// result    result                done, one cycle
//
// Each word goes through capture, store access and result. The store's
// registered read sets the middle step. busy is high from capture until the
// result cycle ends. Reset empties both stacks; store contents stay as they
// are. The receiver cannot stall: result is valid only while done is high.
// ----------------------------------------------------------------------------
module dual_stack_shared_array #(
	parameter int unsigned DEPTH = dssa_pkg::DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  dssa_pkg::dssa_cmd_t cmd,
	output logic                done,
	output dssa_pkg::dssa_res_t result
);

	dssa_pkg::dssa_ctl_t ctl;

	dssa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl)
	);

	dssa_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.cmd    (cmd),
		.result (result)
	);

endmodule

[rtl/dssa_ram.sv]
// ----------------------------------------------------------------------------
// dssa_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module dssa_ram #(
	parameter int unsigned W  = dssa_pkg::WORD_W,
	parameter int unsigned D  = dssa_pkg::DEPTH_DEF,
	localparam int unsigned AW = $clog2(D)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem_q [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/dssa_datapath.sv]
// ----------------------------------------------------------------------------
// dssa_datapath
// Stack counts, full/empty decisions, store access and result formatting.
// ----------------------------------------------------------------------------
module dssa_datapath #(
	parameter int unsigned DEPTH = dssa_pkg::DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dssa_pkg::dssa_ctl_t ctl,
	input  dssa_pkg::dssa_cmd_t cmd,
	output dssa_pkg::dssa_res_t result
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	dssa_pkg::dssa_cmd_t         cmd_q;
	logic [CW-1:0]               lower_q;
	logic [CW-1:0]               upper_q;
	logic [dssa_pkg::STATUS_W-1:0] status_q;
	logic                        rd_ok_q;

	logic [CW:0]   used;
	logic          full;
	logic          empty;
	logic          push_ok;
	logic          pop_ok;
	logic [CW-1:0] waddr_w;
	logic [CW-1:0] raddr_w;
	logic [dssa_pkg::WORD_W-1:0] rdata;

	assign used  = {1'b0, lower_q} + {1'b0, upper_q};
	assign full  = used >= (CW+1)'(DEPTH);
	assign empty = (cmd_q.stack_select == dssa_pkg::SEL_LOWER) ?
		(lower_q == '0) : (upper_q == '0);
	assign push_ok = (cmd_q.opcode == dssa_pkg::OP_PUSH) && !full;
	assign pop_ok  = (cmd_q.opcode == dssa_pkg::OP_POP) && !empty;

	// lower grows up from 0, upper grows down from DEPTH-1
	assign waddr_w = (cmd_q.stack_select == dssa_pkg::SEL_LOWER) ?
		lower_q : (CW'(DEPTH - 1) - upper_q);
	assign raddr_w = (cmd_q.stack_select == dssa_pkg::SEL_LOWER) ?
		(lower_q - CW'(1)) : (CW'(DEPTH) - upper_q);

	dssa_ram #(
		.W (dssa_pkg::WORD_W),
		.D (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ctl.exec && push_ok),
		.waddr (waddr_w[AW-1:0]),
		.wdata (cmd_q.push_value),
		.re    (ctl.exec && pop_ok),
		.raddr (raddr_w[AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q  <= '0;
			upper_q  <= '0;
			status_q <= dssa_pkg::ST_OK;
			rd_ok_q  <= 1'b0;
		end else if (ctl.exec) begin
			rd_ok_q <= pop_ok;
			if (cmd_q.opcode == dssa_pkg::OP_PUSH) begin
				status_q <= full ? dssa_pkg::ST_OVERFLOW : dssa_pkg::ST_OK;
			end else begin
				status_q <= empty ? dssa_pkg::ST_UNDERFLOW : dssa_pkg::ST_OK;
			end
			if (push_ok) begin
				if (cmd_q.stack_select == dssa_pkg::SEL_LOWER) begin
					lower_q <= lower_q + CW'(1);
				end else begin
					upper_q <= upper_q + CW'(1);
				end
			end
			if (pop_ok) begin
				if (cmd_q.stack_select == dssa_pkg::SEL_LOWER) begin
					lower_q <= lower_q - CW'(1);
				end else begin
					upper_q <= upper_q - CW'(1);
				end
			end
		end
	end

	always_comb begin
		result.status = status_q;
		if (rd_ok_q) begin
			result.pop_value = rdata;
		end else if (status_q == dssa_pkg::ST_UNDERFLOW) begin
			result.pop_value = '1;
		end else begin
			result.pop_value = '0;
		end
	end

endmodule

[rtl/dssa_ctrl.sv]
// ----------------------------------------------------------------------------
// dssa_ctrl
// Sequencer: take a word, execute it against the store, present the result.
// ----------------------------------------------------------------------------
module dssa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	output dssa_pkg::dssa_ctl_t ctl
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_RESP = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: state_d = S_RESP;
			S_RESP: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = (state_q == S_RESP);
	assign ctl.latch = (state_q == S_IDLE) && start;
	assign ctl.exec  = (state_q == S_EXEC);

endmodule
